FILE: sv/dcd_pkg.sv
// ----------------------------------------------------------------------------
// Directed cycle detector package
// Field widths, reset values and opcodes shared by the detector files.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int VERTEX_W             = 6;
    localparam int OPCODE_W             = 2;
    localparam int COUNT_W              = 7;
    localparam int MAX_VERTICES_DEFAULT = 64;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY    = 2'd2;

endpackage

FILE: sv/dcd_if.sv
// ----------------------------------------------------------------------------
// Directed cycle detector channels
// Command channel and result channel, each with valid/ready and payload.
// ----------------------------------------------------------------------------
interface dcd_in_if import dcd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
    logic [VERTEX_W-1:0] source_vertex;
    logic                whole_graph;

    modport source (output valid, output opcode, output from_vertex, output to_vertex,
                    output source_vertex, output whole_graph, input ready);
    modport sink   (input valid, input opcode, input from_vertex, input to_vertex,
                    input source_vertex, input whole_graph, output ready);
endinterface

interface dcd_out_if ();
    logic valid;
    logic ready;
    logic has_cycle;

    modport source (output valid, output has_cycle, input ready);
    modport sink   (input valid, input has_cycle, output ready);
endinterface

FILE: sv/dcd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/directed_cycle_detect_top.sv
// ----------------------------------------------------------------------------
// Directed cycle detector
// Adjacency matrix in RAM; a query runs a depth-first walk with a stack RAM.
// Add edge: read, modify and write of the row in S_EDGE_RD and S_EDGE_WR. Clear all edges at once.
// Query: each walk step uses the single row read and find-first unit once; a push passes
// through S_ROW_RD and S_ROW_EVAL, and a pop also through S_POP_WAIT.
// One item at a time; a result waits in its register until taken.
// Reset (async, active low) empties the graph through per-row valid bits.
// ----------------------------------------------------------------------------
module directed_cycle_detect_top import dcd_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    dcd_in_if.sink             req,
    dcd_out_if.source          rsp,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int XW = ((VW > VERTEX_W) ? VW : VERTEX_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_SCAN,
        S_ROW_RD,
        S_ROW_EVAL,
        S_POP_WAIT,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [VW-1:0]           top_reg, top_next;
    logic [CW-1:0]           depth_reg, depth_next;
    logic [CW-1:0]           scan_reg, scan_next;
    logic                    whole_reg, whole_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] on_path_reg, on_path_next;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [VW-1:0]           from_reg, from_next;
    logic [VW-1:0]           to_reg, to_next;
    logic                    has_cycle_reg, has_cycle_next;
    logic [COUNT_W-1:0]      vertex_count_reg;

    logic                    adj_we;
    logic [VW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic [MAX_VERTICES-1:0] row;
    logic [MAX_VERTICES-1:0] fresh;
    logic [VW-1:0]           fresh_v;

    logic                    stk_we;
    logic [VW-1:0]           stk_waddr;
    logic [VW-1:0]           stk_wdata;
    logic [VW-1:0]           stk_raddr;
    logic [VW-1:0]           stk_rdata;
    logic [CW-1:0]           depth_m2;

    logic [XW-1:0]           from_x, to_x, src_x;
    logic                    from_ok, to_ok, src_ok;
    logic [LW-1:0]           count_x, limit;
    logic                    start_go;
    logic [VW-1:0]           start_v;

    // Lowest set bit of a vertex mask; this is the walk's find-first unit.
    function automatic logic [VW-1:0] lowest_set(input logic [MAX_VERTICES-1:0] bits);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

    dcd_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (from_reg),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dcd_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign from_x  = XW'(req.from_vertex);
    assign to_x    = XW'(req.to_vertex);
    assign src_x   = XW'(req.source_vertex);
    assign from_ok = from_x < XW'(MAX_VERTICES);
    assign to_ok   = to_x < XW'(MAX_VERTICES);
    assign src_ok  = src_x < XW'(MAX_VERTICES);

    assign count_x = LW'(vertex_count_reg);
    assign limit   = (count_x > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : count_x;

    // A row that was never written since the last clear reads as empty.
    // The edge add keeps its row address through S_EDGE_RD and S_EDGE_WR so that the valid
    // bit matches the row whose read data arrives in S_EDGE_WR.
    assign adj_raddr = (state_reg inside {S_EDGE_RD, S_EDGE_WR}) ? from_reg : top_reg;
    assign row       = row_valid_reg[adj_raddr] ? adj_rdata : '0;
    assign adj_wdata = row | (MAX_VERTICES'(1) << to_reg);
    assign fresh     = row & ~visited_reg;
    assign fresh_v   = lowest_set(fresh);

    // The entry under the top is read while the top is popped.
    assign depth_m2  = depth_reg - CW'(2);
    assign stk_raddr = depth_m2[VW-1:0];

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = (state_reg == S_DONE);
    assign rsp.has_cycle = has_cycle_reg;

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        depth_next     = depth_reg;
        scan_next      = scan_reg;
        whole_next     = whole_reg;
        visited_next   = visited_reg;
        on_path_next   = on_path_reg;
        row_valid_next = row_valid_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        has_cycle_next = has_cycle_reg;
        adj_we         = 1'b0;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[VW-1:0];
        stk_wdata      = fresh_v;
        start_go       = 1'b0;
        start_v        = scan_reg[VW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.opcode)
                        OP_ADD_EDGE:
                        begin
                            if (from_ok && to_ok)
                            begin
                                from_next  = from_x[VW-1:0];
                                to_next    = to_x[VW-1:0];
                                state_next = S_EDGE_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        OP_QUERY:
                        begin
                            visited_next = '0;
                            on_path_next = '0;
                            whole_next   = req.whole_graph;
                            if (req.whole_graph)
                            begin
                                scan_next  = '0;
                                state_next = S_SCAN;
                            end
                            else if (src_ok)
                            begin
                                start_go = 1'b1;
                                start_v  = src_x[VW-1:0];
                            end
                            else
                            begin
                                has_cycle_next = 1'b0;
                                state_next     = S_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EDGE_RD:
            begin
                state_next = S_EDGE_WR;
            end
            S_EDGE_WR:
            begin
                adj_we                   = 1'b1;
                row_valid_next[from_reg] = 1'b1;
                state_next               = S_IDLE;
            end
            S_SCAN:
            begin
                if (LW'(scan_reg) >= limit)
                begin
                    has_cycle_next = 1'b0;
                    state_next     = S_DONE;
                end
                else if (visited_reg[scan_reg[VW-1:0]])
                begin
                    scan_next = scan_reg + CW'(1);
                end
                else
                begin
                    start_go = 1'b1;
                end
            end
            S_ROW_RD:
            begin
                state_next = S_ROW_EVAL;
            end
            S_ROW_EVAL:
            begin
                if ((row & on_path_reg) != '0)
                begin
                    has_cycle_next = 1'b1;
                    state_next     = S_DONE;
                end
                else if (fresh != '0)
                begin
                    stk_we                = 1'b1;
                    depth_next            = depth_reg + CW'(1);
                    top_next              = fresh_v;
                    visited_next[fresh_v] = 1'b1;
                    on_path_next[fresh_v] = 1'b1;
                    state_next            = S_ROW_RD;
                end
                else
                begin
                    on_path_next[top_reg] = 1'b0;
                    depth_next            = depth_reg - CW'(1);
                    if (depth_reg == CW'(1))
                    begin
                        if (whole_reg)
                        begin
                            scan_next  = scan_reg + CW'(1);
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            has_cycle_next = 1'b0;
                            state_next     = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_POP_WAIT;
                    end
                end
            end
            S_POP_WAIT:
            begin
                top_next   = stk_rdata;
                state_next = S_ROW_RD;
            end
            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A new walk puts its start vertex alone on the stack.
        if (start_go)
        begin
            stk_we                = 1'b1;
            stk_waddr             = '0;
            stk_wdata             = start_v;
            top_next              = start_v;
            depth_next            = CW'(1);
            visited_next[start_v] = 1'b1;
            on_path_next[start_v] = 1'b1;
            state_next            = S_ROW_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            depth_reg        <= '0;
            scan_reg         <= '0;
            whole_reg        <= 1'b0;
            visited_reg      <= '0;
            on_path_reg      <= '0;
            row_valid_reg    <= '0;
            has_cycle_reg    <= 1'b0;
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            scan_reg      <= scan_next;
            whole_reg     <= whole_next;
            visited_reg   <= visited_next;
            on_path_reg   <= on_path_next;
            row_valid_reg <= row_valid_next;
            has_cycle_reg <= has_cycle_next;
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        from_reg <= from_next;
        to_reg   <= to_next;
    end

    // The block never takes a command while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n) !(req.ready && rsp.valid))
        else $error("command accepted while a result is pending");

    // Every vertex on the current path has been visited.
    assert property (@(posedge clk) disable iff (!rst_n) (on_path_reg & ~visited_reg) == '0)
        else $error("on-path vertex not marked visited");

    // The walk stack never grows beyond the vertex count.
    assert property (@(posedge clk) disable iff (!rst_n) depth_reg <= CW'(MAX_VERTICES))
        else $error("walk stack overflow");

    // Clearing the graph empties every row at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.opcode == OP_CLEAR) |=> row_valid_reg == '0)
        else $error("graph not empty after clear");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Directed cycle detector testbench
// Drives edge adds, clears and cycle queries into the detector over its
// valid/ready command channel and checks every has_cycle beat against the table's
// expectation or a depth-first-walk predictor. A short stimulus table runs first, followed by
// randomly built graphs under several vertex_count settings, with random
// gaps on both channels and one long result hold-off per setting.
// ----------------------------------------------------------------------------
module tb_top;
    import dcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV          = MAX_VERTICES_DEFAULT;
    localparam int QUIET       = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 230;
    localparam int LIMIT_NS    = 30_000_000;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
        logic [VERTEX_W-1:0] source_vertex;
        logic                whole_graph;
        logic                checked;
        logic                cycle;
    } row_t;

    // Columns: opcode, from, to, source, whole, checked, expected has_cycle.
    // Rows with checked low take their expectation from the predictor.
    localparam row_t DIRECTED_ROWS [24] = '{
        '{OP_QUERY,    6'd0,  6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_QUERY,    6'd63, 6'd63, 6'd0,  1'b0, 1'b1, 1'b0},
        '{OP_UNUSED,   6'd63, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
        '{OP_ADD_EDGE, 6'd63, 6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,    6'd0,  6'd0,  6'd63, 1'b0, 1'b1, 1'b1},
        '{OP_QUERY,    6'd0,  6'd0,  6'd0,  1'b1, 1'b1, 1'b1},
        '{OP_CLEAR,    6'd63, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
        '{OP_QUERY,    6'd0,  6'd0,  6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_ADD_EDGE, 6'd0,  6'd1,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_ADD_EDGE, 6'd0,  6'd1,  6'd63, 1'b1, 1'b0, 1'b0},
        '{OP_ADD_EDGE, 6'd1,  6'd2,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,    6'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_ADD_EDGE, 6'd2,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,    6'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,    6'd0,  6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_ADD_EDGE, 6'd5,  6'd40, 6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_ADD_EDGE, 6'd40, 6'd5,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,    6'd0,  6'd0,  6'd5,  1'b0, 1'b0, 1'b0},
        '{OP_ADD_EDGE, 6'd62, 6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,    6'd63, 6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{OP_CLEAR,    6'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,    6'd0,  6'd0,  6'd5,  1'b0, 1'b1, 1'b0},
        '{OP_QUERY,    6'd63, 6'd63, 6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_UNUSED,   6'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    dcd_in_if  req_if ();
    dcd_out_if rsp_if ();

    directed_cycle_detect_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: graph, walk masks, walk stack and vertex_count copy.
    logic [NV-1:0]      graph_rows [NV];
    logic [NV-1:0]      seen_mask;
    logic [NV-1:0]      path_mask;
    int                 walk_stk [NV];
    logic [COUNT_W-1:0] vertex_limit = VERTEX_COUNT_RESET;

    logic has_cycle_q [$];
    logic head_cycle;
    int   failures     = 0;
    int   items_taken  = 0;
    bit   calm         = 1'b0;
    bit   hold_pending = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [VERTEX_W-1:0] rand_vertex();
        return VERTEX_W'($urandom_range(0, NV - 1));
    endfunction

    function automatic row_t make_cmd(logic [OPCODE_W-1:0] op, logic [VERTEX_W-1:0] f,
                                      logic [VERTEX_W-1:0] t, logic [VERTEX_W-1:0] s,
                                      logic w);
        row_t r;
        r.opcode        = op;
        r.from_vertex   = f;
        r.to_vertex     = t;
        r.source_vertex = s;
        r.whole_graph   = w;
        r.checked       = 1'b0;
        r.cycle         = 1'b0;
        return r;
    endfunction

    // Depth-first walk from an unvisited start; true once the top of the
    // stack has an edge back onto the current path.
    function automatic bit walk_from(int start);
        int               depth;
        int               top;
        int               nxt;
        logic [NV-1:0]    fresh;
        bit               pushed;
        walk_stk[0]      = start;
        depth            = 1;
        seen_mask[start] = 1'b1;
        path_mask[start] = 1'b1;
        while (depth > 0)
        begin
            top = walk_stk[depth - 1];
            if ((graph_rows[top] & path_mask) != '0)
            begin
                return 1'b1;
            end
            fresh  = graph_rows[top] & ~seen_mask;
            pushed = 1'b0;
            if (fresh != '0 && depth < NV)
            begin
                nxt = 0;
                for (int b = NV - 1; b >= 0; b--)
                begin
                    if (fresh[b])
                    begin
                        nxt = b;
                    end
                end
                walk_stk[depth] = nxt;
                depth++;
                seen_mask[nxt] = 1'b1;
                path_mask[nxt] = 1'b1;
                pushed         = 1'b1;
            end
            if (!pushed)
            begin
                path_mask[top] = 1'b0;
                depth--;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit predict_cycle(logic whole, logic [VERTEX_W-1:0] src);
        int limit;
        bit found;
        seen_mask = '0;
        path_mask = '0;
        found     = 1'b0;
        if (whole)
        begin
            limit = (int'(vertex_limit) < NV) ? int'(vertex_limit) : NV;
            for (int v = 0; v < limit && !found; v++)
            begin
                if (!seen_mask[v])
                begin
                    found = walk_from(v);
                end
            end
        end
        else if (int'(src) < NV)
        begin
            found = walk_from(int'(src));
        end
        return found;
    endfunction

    // Offers one command beat, waits for the handshake, then updates the
    // predictor. Valid stays high when the next beat follows without a gap.
    task automatic drive_item(input row_t r);
        int   gap;
        logic found;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.opcode        <= r.opcode;
        req_if.from_vertex   <= r.from_vertex;
        req_if.to_vertex     <= r.to_vertex;
        req_if.source_vertex <= r.source_vertex;
        req_if.whole_graph   <= r.whole_graph;
        req_if.valid         <= 1'b1;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        case (r.opcode)
            OP_ADD_EDGE:
            begin
                graph_rows[r.from_vertex][r.to_vertex] = 1'b1;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NV; i++)
                begin
                    graph_rows[i] = '0;
                end
            end
            OP_QUERY:
            begin
                found = r.checked ? r.cycle : predict_cycle(r.whole_graph, r.source_vertex);
                has_cycle_q.insert(has_cycle_q.size(), found);
            end
            default:
            begin
            end
        endcase
        if (r.opcode != OP_UNUSED)
        begin
            items_taken++;
        end
    endtask

    // Drops valid, waits for every result, then lets a trailing edge add or
    // clear finish inside the block.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (has_cycle_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        vertex_limit  = value;
    endtask

    // One random graph, after an optional clear: a DAG over a scattered vertex set, sometimes
    // closed into a cycle by a back edge or self loop, then a few queries and maybe a random command.
    task automatic run_random_graph();
        int                  n;
        int                  base;
        int                  stride;
        int                  a;
        int                  b;
        logic [VERTEX_W-1:0] vmap [NV];
        logic [VERTEX_W-1:0] src;
        calm   = ($urandom_range(0, 5) == 0);
        n      = ($urandom_range(0, 19) == 0) ? NV : $urandom_range(2, 12);
        base   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, NV - 1);
        stride = 2 * $urandom_range(0, 31) + 1;
        for (int i = 0; i < n; i++)
        begin
            vmap[i] = VERTEX_W'((base + i * stride) % NV);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            drive_item(make_cmd(OP_CLEAR, rand_vertex(), rand_vertex(), rand_vertex(),
                                1'($urandom_range(0, 1))));
        end
        if (n == NV)
        begin
            // A full-length chain pushes the walk stack to its deepest.
            for (int i = 0; i < n - 1; i++)
            begin
                drive_item(make_cmd(OP_ADD_EDGE, vmap[i], vmap[i + 1], rand_vertex(),
                                    1'($urandom_range(0, 1))));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 2 * n))
            begin
                a = $urandom_range(0, n - 2);
                b = $urandom_range(a + 1, n - 1);
                drive_item(make_cmd(OP_ADD_EDGE, vmap[a], vmap[b], rand_vertex(),
                                    1'($urandom_range(0, 1))));
            end
        end
        if ($urandom_range(0, 1) == 1)
        begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, a);
            drive_item(make_cmd(OP_ADD_EDGE, vmap[a], vmap[b], rand_vertex(),
                                1'($urandom_range(0, 1))));
        end
        repeat ($urandom_range(1, 3))
        begin
            src = ($urandom_range(0, 3) != 0) ? vmap[$urandom_range(0, n - 1)] : rand_vertex();
            drive_item(make_cmd(OP_QUERY, rand_vertex(), rand_vertex(), src,
                                1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 7) == 0)
        begin
            drive_item(make_cmd(OPCODE_W'($urandom_range(0, 3)), rand_vertex(), rand_vertex(),
                                rand_vertex(), 1'($urandom_range(0, 1))));
        end
    endtask

    initial
    begin
        int runlen;
        int stall;
        rsp_if.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else
            begin
                runlen = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
                rsp_if.ready <= 1'b1;
                repeat (runlen) @(posedge clk);
                stall = pick_gap();
                if (stall != 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (has_cycle_q.size() == 0)
            begin
                $error("has_cycle: beat with no query waiting, actual %0b", rsp_if.has_cycle);
                failures++;
            end
            else
            begin
                head_cycle = has_cycle_q.pop_front();
                if (rsp_if.has_cycle !== head_cycle)
                begin
                    $error("has_cycle mismatch: expected %0b, actual %0b",
                           head_cycle, rsp_if.has_cycle);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        logic [COUNT_W-1:0] counts [5];
        int                 target;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.opcode        = OP_ADD_EDGE;
        req_if.from_vertex   = '0;
        req_if.to_vertex     = '0;
        req_if.source_vertex = '0;
        req_if.whole_graph   = 1'b0;
        for (int i = 0; i < NV; i++)
        begin
            graph_rows[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 24; i++)
        begin
            drive_item(DIRECTED_ROWS[i]);
        end

        // Over-range, single vertex, zero, a random middle value and full.
        counts[0] = 7'd127;
        counts[1] = 7'd1;
        counts[2] = 7'd0;
        counts[3] = COUNT_W'($urandom_range(2, NV - 1));
        counts[4] = 7'd64;
        for (int p = 0; p < 5; p++)
        begin
            write_vertex_count(counts[p]);
            hold_pending = 1'b1;
            target       = items_taken + PHASE_ITEMS;
            while (items_taken < target)
            begin
                run_random_graph();
            end
        end

        settle();
        if (has_cycle_q.size() != 0)
        begin
            $error("has_cycle: %0d queries left without a result", has_cycle_q.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/dcd_pkg.sv
sv/dcd_if.sv
sv/dcd_ram.sv
sv/directed_cycle_detect_top.sv
sim/tb_top.sv
